// ----- rtl/core/ptas_pkg.sv -----
// Shared types, constants and helper functions of the pan/tilt angle smoother.
// Angles are signed fixed point degrees with FRACTION_BITS fraction bits.
// No dependencies; every other file of the block imports this package.
package ptas_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int ANG_W         = 32;
  localparam int MAG_W         = ANG_W + 1;
  localparam int CNT_W         = $clog2(MAG_W + 1);
  localparam int STEPS_W       = 10;
  localparam int DIVR_W        = STEPS_W + 1;
  localparam int CFG_IDX_W     = 2;
  localparam int IN_W          = 72;
  localparam int OUT_W         = 72;

  localparam logic signed [MAG_W-1:0] FULL_TURN = MAG_W'(360 << FRACTION_BITS);
  localparam logic signed [MAG_W-1:0] HALF_TURN = MAG_W'(180 << FRACTION_BITS);
  // A difference snaps when |diff| * 100 < one degree, i.e. |diff| <= SNAP_LIMIT.
  localparam logic [MAG_W-1:0] SNAP_LIMIT = MAG_W'(((1 << FRACTION_BITS) - 1) / 100);

  // A full turn is TURN_ODD << TURN_SHIFT (360 = 45 * 8), so its remainder keeps the
  // low TURN_SHIFT bits and reduces the upper WQ_W bits modulo TURN_ODD.
  localparam int TURN_SHIFT  = FRACTION_BITS + 3;
  localparam int TURN_ODD    = 45;
  localparam int WQ_W        = ANG_W - TURN_SHIFT;
  localparam int RECIP_SHIFT = WQ_W + 6;
  localparam int RECIP_W     = WQ_W + 1;
  // Rounded-up reciprocal of TURN_ODD; its error is small enough that the quotient
  // is exact for every WQ_W-bit operand.
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + TURN_ODD - 1) / TURN_ODD);
  localparam int                   WRAP_PH_W = 2;
  localparam logic [WRAP_PH_W-1:0] WRAP_LAST = WRAP_PH_W'(3);

  localparam logic signed [ANG_W-1:0] RESET_TILT  = ANG_W'(90 << FRACTION_BITS);
  localparam logic [STEPS_W-1:0]      RESET_STEPS = STEPS_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_TILT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TILT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_STEPS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_PAN     = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [ANG_W-1:0] min_tilt;
    logic signed [ANG_W-1:0] max_tilt;
    logic [DIVR_W-1:0]       step_div;
    logic                    wrap_pan;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
    logic [MAG_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic signed [ANG_W-1:0] clamp_tilt(
    input logic signed [ANG_W-1:0] v,
    input logic signed [ANG_W-1:0] lo,
    input logic signed [ANG_W-1:0] hi
  );
    logic signed [ANG_W-1:0] t;
    t = (v < hi) ? v : hi;
    return (t > lo) ? t : lo;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

// ----- rtl/core/pan_tilt_angle_smoother_unit.sv -----
// Angles already on target go straight to the result; else pan wraps first when enabled,
// then the angles jump or take one interpolation step, which may snap them onto target.
// Each interpolation step (tilt, then pan) is a pass of the one shared divider;
// each pan wrap remainder comes from a pipelined reciprocal multiplication.
// One item in work at a time; the next is accepted after the result is registered.
// Reset (rst, synchronous): angles and limits to reset values, no result.
module pan_tilt_angle_smoother_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // load_pan[0], pan_value[32:1], load_tilt[33], tilt_value[65:34], interpolate[66]
  input  logic [ptas_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tilt_out[31:0], pan_out[63:32], moving[64]
  output logic [ptas_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptas_pkg::ANG_W-1:0]     cfg_data
);
  import ptas_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_WRAP_T = 9'b000000100,
    S_WRAP_D = 9'b000001000,
    S_SMOOTH = 9'b000010000,
    S_DIV_T  = 9'b000100000,
    S_DIV_P  = 9'b001000000,
    S_SNAP   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t   state;
  cfg_t     cfg;
  logic     reclamp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [ANG_W-1:0] pan_target;
  logic signed [ANG_W-1:0] tilt_target;
  logic signed [ANG_W-1:0] pan_current;
  logic signed [ANG_W-1:0] tilt_current;
  logic                    interp;
  logic                    moving;
  logic                    div_neg;
  logic signed [MAG_W-1:0] d_wrap;

  logic                    out_valid;
  logic [ANG_W-1:0]        out_tilt;
  logic [ANG_W-1:0]        out_pan;
  logic                    out_moving;

  logic                    in_accept;
  logic                    in_load_pan;
  logic signed [ANG_W-1:0] in_pan;
  logic                    in_load_tilt;
  logic signed [ANG_W-1:0] in_tilt;
  logic                    in_interp;

  logic signed [MAG_W-1:0] tilt_diff;
  logic signed [MAG_W-1:0] pan_diff;
  logic                    moving_now;
  logic                    near_both;

  logic [WRAP_PH_W-1:0]    wrap_phase;
  logic [MAG_W-1:0]        wrap_abs;
  logic [WQ_W-1:0]         wrap_hi;
  logic [TURN_SHIFT-1:0]   wrap_lo;
  logic [WQ_W+RECIP_W-1:0] wrap_prod;
  logic [WQ_W-1:0]         wrap_q;

  logic [MAG_W-1:0]        rem;
  logic [MAG_W-1:0]        wrapped_target;
  logic [MAG_W-1:0]        fmod;
  logic signed [MAG_W-1:0] folded;
  logic signed [MAG_W-1:0] d_new;
  logic signed [MAG_W-1:0] wrapped_current;

  logic signed [MAG_W:0]   step_q;
  logic signed [ANG_W-1:0] step_base;
  logic signed [MAG_W:0]   step_sum;

  ptas_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .reclamp   (reclamp)
  );

  ptas_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_load_pan  = s_axis_tdata[0];
  assign in_pan       = s_axis_tdata[ANG_W:1];
  assign in_load_tilt = s_axis_tdata[ANG_W+1];
  assign in_tilt      = s_axis_tdata[2*ANG_W+1:ANG_W+2];
  assign in_interp    = s_axis_tdata[2*ANG_W+2];

  // Config writes and the re-clamp that follows a limit write go ahead of a new item.
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid && !reclamp;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign tilt_diff  = {tilt_target[ANG_W-1], tilt_target} -
                      {tilt_current[ANG_W-1], tilt_current};
  assign pan_diff   = {pan_target[ANG_W-1], pan_target} -
                      {pan_current[ANG_W-1], pan_current};
  assign moving_now = (tilt_diff != '0) || (pan_diff != '0);
  assign near_both  = (magnitude(tilt_diff) <= SNAP_LIMIT) &&
                      (magnitude(pan_diff) <= SNAP_LIMIT);

  // Remainder of a magnitude by a full turn. The operand holds still during a wrap
  // state, so the registers below (wrap_hi/wrap_lo, wrap_q, rem) hold it by the last phase.
  assign wrap_abs  = (state == S_WRAP_T) ? magnitude({pan_target[ANG_W-1], pan_target})
                                         : magnitude(d_wrap);
  assign wrap_prod = wrap_hi * RECIP_MULT;

  always_ff @(posedge clk) begin
    wrap_hi <= wrap_abs[ANG_W-1:TURN_SHIFT];
    wrap_lo <= wrap_abs[TURN_SHIFT-1:0];
    wrap_q  <= WQ_W'(wrap_prod[WQ_W+RECIP_W-1:RECIP_SHIFT]);
    rem     <= MAG_W'({wrap_hi - wrap_q * WQ_W'(TURN_ODD), wrap_lo});
  end

  // Pan wrap. The target becomes its floor remainder by a full turn (a negative
  // exact multiple gives a full turn). The original target-to-current difference
  // is folded into one turn around zero and the current pan is rebuilt from it.
  always_comb begin
    wrapped_target = div_neg ? $unsigned(FULL_TURN) - rem : rem;
    fmod           = (div_neg && (rem != '0)) ? $unsigned(FULL_TURN) - rem : rem;
    folded         = (fmod >= $unsigned(HALF_TURN)) ? $signed(fmod) - FULL_TURN
                                                    : $signed(fmod);
    if ((d_wrap >= -HALF_TURN) && (d_wrap <= HALF_TURN)) begin
      d_new = d_wrap;
    end else if ((d_wrap > HALF_TURN) && (folded == -HALF_TURN)) begin
      d_new = HALF_TURN;
    end else begin
      d_new = folded;
    end
    wrapped_current = {pan_target[ANG_W-1], pan_target} - d_new;
  end

  // Interpolation step: current plus the signed, truncated quotient.
  always_comb begin
    step_q    = div_neg ? -$signed({1'b0, div_rsp.quotient})
                        : $signed({1'b0, div_rsp.quotient});
    step_base = (state == S_DIV_T) ? tilt_current : pan_current;
    step_sum  = {{2{step_base[ANG_W-1]}}, step_base} + step_q;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = magnitude(tilt_diff);
    div_req.divisor  = MAG_W'(cfg.step_div);
    case (state)
      S_SMOOTH: begin
        div_req.start = interp;
      end
      S_DIV_T: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = magnitude(pan_diff);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pan_target   <= '0;
      tilt_target  <= RESET_TILT;
      pan_current  <= '0;
      tilt_current <= RESET_TILT;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (reclamp) begin
            tilt_target <= clamp_tilt(tilt_target, cfg.min_tilt, cfg.max_tilt);
          end
          if (in_accept) begin
            if (in_load_pan) begin
              pan_target <= in_pan;
            end
            if (in_load_tilt) begin
              tilt_target <= clamp_tilt(in_tilt, cfg.min_tilt, cfg.max_tilt);
            end
            interp <= in_interp;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          moving     <= moving_now;
          d_wrap     <= pan_diff;
          div_neg    <= pan_target[ANG_W-1];
          wrap_phase <= '0;
          if (!moving_now) begin
            state <= S_OUT;
          end else if (cfg.wrap_pan) begin
            state <= S_WRAP_T;
          end else begin
            state <= S_SMOOTH;
          end
        end
        S_WRAP_T: begin
          if (wrap_phase == WRAP_LAST) begin
            pan_target <= wrapped_target[ANG_W-1:0];
            div_neg    <= d_wrap[MAG_W-1];
            wrap_phase <= '0;
            state      <= S_WRAP_D;
          end else begin
            wrap_phase <= wrap_phase + WRAP_PH_W'(1);
          end
        end
        S_WRAP_D: begin
          if (wrap_phase == WRAP_LAST) begin
            pan_current <= wrapped_current[ANG_W-1:0];
            state       <= S_SMOOTH;
          end else begin
            wrap_phase <= wrap_phase + WRAP_PH_W'(1);
          end
        end
        S_SMOOTH: begin
          if (interp) begin
            div_neg <= tilt_diff[MAG_W-1];
            state   <= S_DIV_T;
          end else begin
            tilt_current <= tilt_target;
            pan_current  <= pan_target;
            state        <= S_OUT;
          end
        end
        S_DIV_T: begin
          if (div_rsp.done) begin
            tilt_current <= step_sum[ANG_W-1:0];
            div_neg      <= pan_diff[MAG_W-1];
            state        <= S_DIV_P;
          end
        end
        S_DIV_P: begin
          if (div_rsp.done) begin
            pan_current <= step_sum[ANG_W-1:0];
            state       <= S_SNAP;
          end
        end
        S_SNAP: begin
          if (near_both) begin
            tilt_current <= tilt_target;
            pan_current  <= pan_target;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_tilt   <= tilt_current;
            out_pan    <= pan_current;
            out_moving <= moving;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_W - 2 * ANG_W - 1)'(0), out_moving, out_pan, out_tilt};

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == S_IDLE))
    else $error("input ready outside the idle state");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_T || state == S_DIV_P))
    else $error("divider finished while no state waits for it");

  a_result_registered: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || m_axis_tready)) |=>
      (m_axis_tvalid && state == S_IDLE))
    else $error("finished item not moved into the output register");

endmodule

// ----- rtl/core/ptas_div.sv -----
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// A pass runs from start until every quotient bit is in; done pulses for one cycle.
// Depends on ptas_pkg.
module ptas_div (
  input  logic               clk,
  input  logic               rst,
  input  ptas_pkg::div_req_t req,
  output ptas_pkg::div_rsp_t rsp
);
  import ptas_pkg::*;

  logic [MAG_W-1:0] acc;
  logic [MAG_W-1:0] quo;
  logic [MAG_W-1:0] dvsr;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic             done;
  logic [MAG_W:0]   shifted;
  logic [MAG_W+1:0] trial;
  logic             fits;

  assign shifted = {acc, quo[MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvsr};
  assign fits    = ~trial[MAG_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc    <= '0;
        quo    <= req.dividend;
        dvsr   <= req.divisor;
        cnt    <= CNT_W'(MAG_W);
        active <= 1'b1;
      end else if (active) begin
        acc <= fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
        quo <= {quo[MAG_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !active)
    else $error("divider restarted while a pass is running");

  a_done_ends_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(active) && !active))
    else $error("divider done without a finished pass");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (acc < dvsr))
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/ptas_cfg.sv -----
// Configuration register file: tilt limits, smoothing divisor and pan wrap flag.
// Flags a re-clamp of the tilt target in the cycle after a limit write.
// Depends on ptas_pkg.
module ptas_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptas_pkg::ANG_W-1:0]     cfg_data,
  output ptas_pkg::cfg_t                 cfg,
  output logic                           reclamp
);
  import ptas_pkg::*;

  // Zero steps act as one; the divisor is steps plus one.
  function automatic logic [DIVR_W-1:0] step_divisor(input logic [STEPS_W-1:0] steps);
    return (steps == '0) ? DIVR_W'(2) : DIVR_W'(steps) + DIVR_W'(1);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_tilt <= -RESET_TILT;
      cfg.max_tilt <= RESET_TILT;
      cfg.step_div <= step_divisor(RESET_STEPS);
      cfg.wrap_pan <= 1'b0;
      reclamp      <= 1'b0;
    end else begin
      reclamp <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_TILT: begin
            cfg.min_tilt <= cfg_data;
            reclamp      <= 1'b1;
          end
          REG_MAX_TILT: begin
            cfg.max_tilt <= cfg_data;
            reclamp      <= 1'b1;
          end
          REG_SMOOTH_STEPS: begin
            cfg.step_div <= step_divisor(cfg_data[STEPS_W-1:0]);
          end
          REG_WRAP_PAN: begin
            cfg.wrap_pan <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for pan_tilt_angle_smoother_unit: streams move commands,
// predicts every pose with a behavioral model and compares each result item.
// Depends on ptas_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;
  import ptas_pkg::*;

  localparam int     DEG   = 1 << FRACTION_BITS;
  localparam longint TURN  = 360 * DEG;
  localparam longint HALF  = 180 * DEG;
  localparam int     RX_HOLD_CYCLES = 300;

  typedef struct {
    bit load_pan;
    int pan_value;
    bit load_tilt;
    int tilt_value;
    bit interpolate;
  } move_cmd_t;

  typedef struct {
    int tilt_out;
    int pan_out;
    bit moving;
  } pose_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // load_pan[0], pan_value[32:1], load_tilt[33], tilt_value[65:34], interpolate[66]
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // tilt_out[31:0], pan_out[63:32], moving[64]
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ANG_W-1:0]     cfg_data = '0;

  pan_tilt_angle_smoother_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the unit's angles and settings.
  longint      lim_lo   = -90 * DEG;
  longint      lim_hi   = 90 * DEG;
  int unsigned steps    = 8;
  bit          wrap_on  = 1'b0;
  longint      pan_tgt  = 0;
  longint      pan_cur  = 0;
  longint      tilt_tgt = 90 * DEG;
  longint      tilt_cur = 90 * DEG;

  pose_t pending_poses[$];
  pose_t want;
  int    errors = 0;
  int    items_sent = 0;
  int    regs_written = 0;
  int    results_checked = 0;
  bit    idle_on = 1'b1;
  bit    stall_request = 1'b0;

  function automatic longint limit_tilt(input longint v);
    longint t;
    t = (v < lim_hi) ? v : lim_hi;
    return (t > lim_lo) ? t : lim_lo;
  endfunction

  function automatic bit within_snap(input longint d);
    return ((d < 0 ? -d : d) * 100) < DEG;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [ANG_W-1:0] val);
    case (idx)
      REG_MIN_TILT: begin
        lim_lo   = longint'(signed'(val));
        tilt_tgt = limit_tilt(tilt_tgt);
      end
      REG_MAX_TILT: begin
        lim_hi   = longint'(signed'(val));
        tilt_tgt = limit_tilt(tilt_tgt);
      end
      REG_SMOOTH_STEPS: steps = val[STEPS_W-1:0];
      REG_WRAP_PAN:     wrap_on = val[0];
      default: ;
    endcase
  endfunction

  // Loads the targets, wraps pan when enabled, steps or jumps, then snaps.
  function automatic pose_t advance_angles(input move_cmd_t c);
    pose_t  r;
    bit     mv;
    longint nt, d, n, dv;
    if (c.load_pan) pan_tgt = longint'(c.pan_value);
    if (c.load_tilt) tilt_tgt = limit_tilt(longint'(c.tilt_value));
    mv = (tilt_tgt != tilt_cur) || (pan_tgt != pan_cur);
    if (mv) begin
      if (wrap_on) begin
        nt = pan_tgt % TURN;
        if (pan_tgt < 0) nt = nt + TURN;
        pan_cur = pan_cur + (nt - pan_tgt);
        pan_tgt = nt;
        d = pan_tgt - pan_cur;
        if (d < -HALF) begin
          n = (-HALF - d + TURN - 1) / TURN;
          pan_cur = pan_cur - n * TURN;
          d = pan_tgt - pan_cur;
        end
        if (d > HALF) begin
          n = (d - HALF + TURN - 1) / TURN;
          pan_cur = pan_cur + n * TURN;
        end
      end
      if (c.interpolate) begin
        dv = (steps == 0) ? 2 : longint'(steps) + 1;
        tilt_cur = tilt_cur + (tilt_tgt - tilt_cur) / dv;
        pan_cur  = pan_cur + (pan_tgt - pan_cur) / dv;
      end else begin
        tilt_cur = tilt_tgt;
        pan_cur  = pan_tgt;
      end
      if (within_snap(tilt_tgt - tilt_cur) && within_snap(pan_tgt - pan_cur)) begin
        tilt_cur = tilt_tgt;
        pan_cur  = pan_tgt;
      end
    end
    r.tilt_out = int'(tilt_cur);
    r.pan_out  = int'(pan_cur);
    r.moving   = mv;
    return r;
  endfunction

  function automatic int pick_angle(input longint base);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(2 * TURN)) - int'(TURN);
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(2))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          default: return 0;
        endcase
      end
      default: return int'(base) + int'($urandom_range(6)) - 3;
    endcase
  endfunction

  // Leaves tvalid high after acceptance so a following item can go out without a gap.
  task automatic send_cmd(input move_cmd_t c);
    if (idle_on && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (idle_on && $urandom_range(99) < 17);
    end
    s_axis_tdata  <= {5'b0, c.interpolate, c.tilt_value, c.load_tilt, c.pan_value,
                      c.load_pan};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_poses.push_back(advance_angles(c));
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_poses.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, val);
    regs_written++;
  endtask

  task automatic set_config(input int lo, input int hi, input int unsigned steps_word,
                            input int unsigned wrap_word);
    wait_idle();
    write_reg(REG_MIN_TILT, lo);
    write_reg(REG_MAX_TILT, hi);
    write_reg(REG_SMOOTH_STEPS, steps_word);
    write_reg(REG_WRAP_PAN, wrap_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_cmd('{1'b0, 0, 1'b0, 0, 1'b1});
  endtask

  task automatic test_jumps();
    send_cmd('{1'b1, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0});
    send_cmd('{1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0});
    send_cmd('{1'b1, 0, 1'b1, 0, 1'b0});
    send_cmd('{1'b1, -1, 1'b0, -1, 1'b0});
  endtask

  task automatic test_interpolation();
    send_cmd('{1'b1, 100 * DEG, 1'b1, 45 * DEG, 1'b1});
    repeat (3) send_cmd('{1'b0, 0, 1'b0, 0, 1'b1});
    // Both differences within the snap window: the angles land on target.
    send_cmd('{1'b1, int'(pan_cur) + 2, 1'b1, int'(tilt_cur) - 1, 1'b1});
  endtask

  task automatic test_tilt_limits();
    // Crossed limits: every clamped tilt comes out as the lower limit.
    set_config(30 * DEG, -30 * DEG, 8, 0);
    send_cmd('{1'b0, 0, 1'b1, 0, 1'b0});
    set_config(32'h8000_0000, 32'h7fff_ffff, 8, 0);
    send_cmd('{1'b0, 0, 1'b1, 32'h7fff_ffff, 1'b0});
    send_cmd('{1'b0, 0, 1'b1, 32'h8000_0000, 1'b0});
    // Lowering the upper limit pulls the held tilt target down with it.
    send_cmd('{1'b0, 0, 1'b1, 80 * DEG, 1'b0});
    set_config(-90 * DEG, 10 * DEG, 8, 0);
    send_cmd('{1'b0, 0, 1'b0, 0, 1'b0});
  endtask

  task automatic test_step_counts();
    // Zero steps behaves as one; upper data bits must be ignored.
    set_config(-90 * DEG, 90 * DEG, 32'hffff_fc00, 32'hffff_fffe);
    send_cmd('{1'b1, 50 * DEG, 1'b1, -60 * DEG, 1'b1});
    send_cmd('{1'b0, 0, 1'b0, 0, 1'b1});
    set_config(-90 * DEG, 90 * DEG, 1023, 0);
    send_cmd('{1'b1, 32'h7fff_ffff, 1'b1, 90 * DEG, 1'b1});
    send_cmd('{1'b0, 0, 1'b0, 0, 1'b1});
  endtask

  task automatic test_pan_wrap();
    set_config(-90 * DEG, 90 * DEG, 32'h0000_0c03, 32'h8000_0001);
    // An exact negative multiple of a full turn wraps to a full turn.
    send_cmd('{1'b1, -360 * DEG, 1'b0, 0, 1'b0});
    send_cmd('{1'b1, 32'h7fff_ffff, 1'b0, 0, 1'b1});
    send_cmd('{1'b1, 32'h8000_0000, 1'b0, 0, 1'b0});
    send_cmd('{1'b1, 730 * DEG, 1'b1, 5 * DEG, 1'b1});
    send_cmd('{1'b1, -10 * DEG, 1'b0, 0, 1'b1});
    send_cmd('{1'b1, 179 * DEG, 1'b0, 0, 1'b1});
  endtask

  // Mostly a target load followed by settling ticks, with some fully random items.
  task automatic random_run(input int count);
    move_cmd_t c;
    int        sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        c = '{$urandom_range(1), $urandom, $urandom_range(1), $urandom, $urandom_range(1)};
        send_cmd(c);
        sent++;
      end else begin
        c.load_pan    = ($urandom_range(3) != 0);
        c.pan_value   = pick_angle(pan_cur);
        c.load_tilt   = ($urandom_range(3) != 0);
        c.tilt_value  = pick_angle(tilt_cur);
        c.interpolate = ($urandom_range(3) != 0);
        if (!c.load_pan && !c.load_tilt) c.load_tilt = 1'b1;
        send_cmd(c);
        sent++;
        repeat ($urandom_range(24)) begin
          c = '{1'b0, $urandom, 1'b0, $urandom, ($urandom_range(9) != 0)};
          send_cmd(c);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_phases();
    int          lo, hi;
    int unsigned stp;
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(6))
        0: begin
          lo = 32'h8000_0000;
          hi = 32'h7fff_ffff;
        end
        1: begin
          lo = $urandom;
          hi = $urandom;
        end
        default: begin
          lo = -int'($urandom_range(90 * DEG));
          hi = int'($urandom_range(90 * DEG));
        end
      endcase
      stp = (p == 5) ? 1023 : (p == 6) ? 0 : $urandom_range(6, 1);
      set_config(lo, hi, ($urandom << STEPS_W) | stp, ($urandom << 1) | p[0]);
      // Phase 2 runs with no idling on either side.
      idle_on = (p != 2);
      random_run(200);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    stall_request = 1'b1;
    random_run(12);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
      end
      m_axis_tready <= !(idle_on && $urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_checked++;
      if (pending_poses.size() == 0) begin
        $error("unexpected result item: tilt_out %0d, pan_out %0d, moving %0d",
               $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]), m_axis_tdata[64]);
        errors++;
      end else begin
        want = pending_poses.pop_front();
        if ($signed(m_axis_tdata[31:0]) !== want.tilt_out) begin
          $error("tilt_out: expected %0d, actual %0d", want.tilt_out,
                 $signed(m_axis_tdata[31:0]));
          errors++;
        end
        if ($signed(m_axis_tdata[63:32]) !== want.pan_out) begin
          $error("pan_out: expected %0d, actual %0d", want.pan_out,
                 $signed(m_axis_tdata[63:32]));
          errors++;
        end
        if (m_axis_tdata[64] !== want.moving) begin
          $error("moving: expected %0d, actual %0d", want.moving, m_axis_tdata[64]);
          errors++;
        end
      end
    end
  end

  initial begin
    #12ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_jumps();
    test_interpolation();
    test_tilt_limits();
    test_step_counts();
    test_pan_wrap();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    repeat (200) @(posedge clk);
    if (pending_poses.size() != 0) begin
      $error("%0d expected result items never arrived", pending_poses.size());
      errors++;
    end
    $display("Sent %0d move items over %0d register writes; %0d result items checked.",
             items_sent, regs_written, results_checked);
    $display("Covered jumps, smoothing, snapping, tilt clamping and pan wrapping.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- pan_tilt_angle_smoother_unit.f -----
rtl/core/ptas_pkg.sv
rtl/core/ptas_div.sv
rtl/core/ptas_cfg.sv
rtl/core/pan_tilt_angle_smoother_unit.sv
tb/testbench.sv
